>>> rtl/square_matrix_multiply_core_macros.svh
// Assertion macros shared by the square matrix multiply RTL.
// No dependencies; included by smm_seq, the only module that carries assertions.
`ifndef SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/smm_pkg.sv
// Shared types and constants for the square matrix multiply core.
// No dependencies; imported by every module of the block.
package smm_pkg;

	// Field widths fixed by the interface.
	localparam int IDX_W  = 3;
	localparam int DIM_W  = 4;
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	// Exact sum of up to eight products.
	localparam int ACC_W  = PROD_W + 3;
	localparam int FRAC_W = 16;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// Command codes of an input transaction.
	localparam logic [1:0] CMD_WR_A    = 2'd0;
	localparam logic [1:0] CMD_WR_B    = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_WAIT,
		SEQ_ISSUE,
		SEQ_DRAIN
	} seq_state_t;

	// Control that travels alongside one multiply-accumulate step.
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

>>> rtl/square_matrix_multiply_core.sv
// Top level of the square matrix multiply core: ports, stores, output register.
// Depends on smm_pkg, smm_store, smm_mac and smm_seq.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one transaction per command.
//   Write-A and write-B transactions store one Q16.16 element at (row, col)
//   and give no result; rows or columns at or beyond MAX_DIM are dropped.
//   Command 3 is accepted and does nothing.
// - A compute transaction gives every element of C = A * B over the leading
//   matrix_dim square, column by column, row by row, on the output channel
//   (out_valid/out_ready); the final element carries last.
// - Each product element is made in steps: the sequencer claims the output
//   register, issues its reads through the single multiplier (one read per
//   store port per cycle) and drains the pipeline. in_ready is low
//   throughout a compute and rises once the last element sits in the
//   output register.
// - Configuration (cfg_valid/cfg_ready/cfg_data) sets matrix_dim; it is
//   always ready and is meant to be written while the block is idle.
// - Reset clears both stores at once (every entry reads as zero) and sets
//   matrix_dim to 8. If the receiver stalls, the pending element is held and
//   the next one waits for the output register to empty.
module square_matrix_multiply_core
	import smm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	input  logic [IDX_W-1:0]  row_index,
	input  logic [IDX_W-1:0]  col_index,
	input  logic [DATA_W-1:0] element_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  out_row,
	output logic [IDX_W-1:0]  out_col,
	output logic [DATA_W-1:0] result_value,
	output logic              saturated,
	output logic              last
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DIM_W-1:0]  dim_q;
	logic              in_acc;
	logic              wr_ok;
	logic              we_a;
	logic              we_b;
	logic [AW-1:0]     waddr;
	logic              start;
	logic              seq_idle;
	mac_ctl_t          mac_ctl;
	logic [AW-1:0]     a_addr;
	logic [AW-1:0]     b_addr;
	logic [DATA_W-1:0] a_data;
	logic [DATA_W-1:0] b_data;
	logic              mac_done;
	logic [DATA_W-1:0] mac_value;
	logic              mac_sat;
	logic [IDX_W-1:0]  cur_row;
	logic [IDX_W-1:0]  cur_col;
	logic              cur_last;
	logic              out_free;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_row_q;
	logic [IDX_W-1:0]  out_col_q;
	logic [DATA_W-1:0] result_q;
	logic              sat_q;
	logic              last_q;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dim_q <= cfg_data;
		end
	end

	// Input transaction decode.
	assign in_ready = seq_idle;
	assign in_acc   = in_valid && in_ready;
	assign wr_ok    = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
	assign we_a     = in_acc && (command == CMD_WR_A) && wr_ok;
	assign we_b     = in_acc && (command == CMD_WR_B) && wr_ok;
	assign waddr    = AW'(int'(col_index) * MAX_DIM + int'(row_index));
	assign start    = in_acc && (command == CMD_COMPUTE);

	smm_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store_a (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we_a),
		.waddr  (waddr),
		.wdata  (element_value),
		.raddr  (a_addr),
		.rdata  (a_data)
	);

	smm_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store_b (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we_b),
		.waddr  (waddr),
		.wdata  (element_value),
		.raddr  (b_addr),
		.rdata  (b_data)
	);

	smm_seq #(
		.MAX_DIM (MAX_DIM),
		.AW      (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dim      (dim_q),
		.out_free (out_free),
		.done     (mac_done),
		.idle     (seq_idle),
		.ctl      (mac_ctl),
		.a_addr   (a_addr),
		.b_addr   (b_addr),
		.cur_row  (cur_row),
		.cur_col  (cur_col),
		.cur_last (cur_last)
	);

	smm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.a_val     (a_data),
		.b_val     (b_data),
		.done      (mac_done),
		.res_value (mac_value),
		.res_sat   (mac_sat)
	);

	// Output register: filled by a finished element, emptied by the receiver.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mac_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mac_done) begin
			out_row_q <= cur_row;
			out_col_q <= cur_col;
			result_q  <= mac_value;
			sat_q     <= mac_sat;
			last_q    <= cur_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign result_value = result_q;
	assign saturated    = sat_q;
	assign last         = last_q;

endmodule

>>> rtl/smm_store.sv
// Element store: one write port, one registered read port, per-entry valid bits.
// Depends on smm_pkg; instantiated twice by the core for matrices A and B.
module smm_store
	import smm_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [DATA_W-1:0] rd_q;
	logic              rd_vld_q;

	// Storage array, written on a write transaction and read every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Valid bits make an entry never written read as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

>>> rtl/smm_mac.sv
// Shared multiply-accumulate unit with saturating Q16.16 truncation of the sum.
// Depends on smm_pkg; fed by the element stores under the sequencer's control.
module smm_mac
	import smm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mac_ctl_t          ctl,
	input  logic [DATA_W-1:0] a_val,
	input  logic [DATA_W-1:0] b_val,
	output logic              done,
	output logic [DATA_W-1:0] res_value,
	output logic              res_sat
);

	mac_ctl_t          ctl_s1;
	mac_ctl_t          ctl_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [ACC_W-1:0]  acc_q;
	logic              done_q;
	logic              sat_hi;
	logic              sat_lo;

	// Control pipeline, aligned with the store read and the product register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.vld && ctl_s2.last;
		end
	end

	// One signed multiply, then an exact wide accumulate.
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'($signed(a_val) * $signed(b_val));
		if (ctl_s2.vld) begin
			if (ctl_s2.first) begin
				acc_q <= ACC_W'($signed(prod_s2));
			end else begin
				acc_q <= acc_q + ACC_W'($signed(prod_s2));
			end
		end
	end

	// Arithmetic shift right by the fraction width, then clip to 32 bits.
	always_comb begin
		sat_hi = !acc_q[ACC_W-1] && (|acc_q[ACC_W-2:FRAC_W+DATA_W-1]);
		sat_lo = acc_q[ACC_W-1] && !(&acc_q[ACC_W-2:FRAC_W+DATA_W-1]);
		if (sat_hi) begin
			res_value = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sat_lo) begin
			res_value = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			res_value = acc_q[FRAC_W+DATA_W-1:FRAC_W];
		end
	end

	assign res_sat = sat_hi || sat_lo;
	assign done    = done_q;

endmodule

>>> rtl/smm_seq.sv
// Sequencer that walks the product element by element and issues store reads.
// Depends on smm_pkg and the assertion macros; drives the stores and smm_mac.
`include "square_matrix_multiply_core_macros.svh"
module smm_seq
	import smm_pkg::*;
#(
	parameter int MAX_DIM = 8,
	parameter int AW      = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIM_W-1:0] dim,
	input  logic             out_free,
	input  logic             done,
	output logic             idle,
	output mac_ctl_t         ctl,
	output logic [AW-1:0]    a_addr,
	output logic [AW-1:0]    b_addr,
	output logic [IDX_W-1:0] cur_row,
	output logic [IDX_W-1:0] cur_col,
	output logic             cur_last
);

	seq_state_t       state_q;
	seq_state_t       state_d;
	logic [DIM_W-1:0] n_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [DIM_W-1:0] n_act;
	logic             k_end;
	logic             i_end;
	logic             elem_last;

	// Clamp the configured size into the range the stores hold.
	always_comb begin
		if (dim == '0) begin
			n_act = DIM_W'(1);
		end else if (int'(dim) > MAX_DIM) begin
			n_act = DIM_W'(MAX_DIM);
		end else begin
			n_act = dim;
		end
	end

	assign k_end     = ({1'b0, k_q} == n_q - DIM_W'(1));
	assign i_end     = ({1'b0, i_q} == n_q - DIM_W'(1));
	assign elem_last = i_end && ({1'b0, j_q} == n_q - DIM_W'(1));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_d = SEQ_WAIT;
				end
			end
			SEQ_WAIT: begin
				if (out_free) begin
					state_d = SEQ_ISSUE;
				end
			end
			SEQ_ISSUE: begin
				if (k_end) begin
					state_d = SEQ_DRAIN;
				end
			end
			SEQ_DRAIN: begin
				if (done) begin
					state_d = elem_last ? SEQ_IDLE : SEQ_WAIT;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// Outputs: one read of A(i,k) and B(k,j) per step while issuing.
	always_comb begin
		idle      = (state_q == SEQ_IDLE);
		ctl.vld   = (state_q == SEQ_ISSUE);
		ctl.first = (k_q == '0);
		ctl.last  = k_end;
		a_addr    = AW'(int'(k_q) * MAX_DIM + int'(i_q));
		b_addr    = AW'(int'(j_q) * MAX_DIM + int'(k_q));
		cur_row   = i_q;
		cur_col   = j_q;
		cur_last  = elem_last;
	end

	// State and loop counters: column outer, row inner, k innermost.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			n_q     <= DIM_RESET;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				SEQ_IDLE: begin
					if (start) begin
						n_q <= n_act;
						i_q <= '0;
						j_q <= '0;
					end
				end
				SEQ_WAIT: begin
					k_q <= '0;
				end
				SEQ_ISSUE: begin
					if (!k_end) begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				SEQ_DRAIN: begin
					if (done && !elem_last) begin
						if (i_end) begin
							i_q <= '0;
							j_q <= j_q + IDX_W'(1);
						end else begin
							i_q <= i_q + IDX_W'(1);
						end
					end
				end
				default: begin
					k_q <= '0;
				end
			endcase
		end
	end

	`SMM_ASSERT_NOW(a_done_in_drain, clk, arst_n, done, state_q == SEQ_DRAIN, "Result outside drain")
	`SMM_ASSERT_NOW(a_done_out_free, clk, arst_n, done, out_free, "Result while output is full")
	`SMM_ASSERT_NOW(a_k_in_range, clk, arst_n, ctl.vld, DIM_W'(k_q) < n_q, "Inner index too large")
	`SMM_ASSERT_NEXT(a_start_busy, clk, arst_n, start && idle, !idle, "Idle after compute")

endmodule
